// File: hdl/fsca_pkg.sv
package fsca_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int BYTE_W      = 8;
    localparam int KEY_W       = 16;
    localparam int CODE_W      = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CODE_W-1:0] CODE_BASE_RST = 16'h8100;
    localparam logic [BYTE_W-1:0] LEAD_THR_RST  = 8'h81;
    localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_FLUSH,
        OP_PAIR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] trail;
    } t_cmd;

endpackage

// File: hdl/first_seen_code_assigner_top.sv
// Flow: a passed byte goes through the queue, the back end's idle and emit states and
// the output register; a zero after a lead byte gives two bytes, the lead and the zero;
// a pair is scanned against the table before its two code bytes leave.
// Throughput: the queue takes new bytes while the back end works on a command, until it
// is full; a pair's scan reads one stored key per cycle, up to 4096 keys.
// Reset: synchronous, active low; empties queue and table (fill count to zero, no
// clearing pass), code_base to 0x8100 and lead_threshold to 0x81.
module first_seen_code_assigner_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [fsca_pkg::BYTE_W-1:0]       i_in_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [fsca_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                              o_run_last,
    output logic                              o_was_inserted,
    input  logic                              i_cfg_we,
    input  logic [fsca_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fsca_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fsca_pkg::*;

    logic [CODE_W-1:0] r_code_base;
    logic [BYTE_W-1:0] r_lead_threshold;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_push;
    logic              w_pop;
    t_cmd              w_push_cmd;
    t_cmd              w_q_head;
    logic [FILL_W-1:0] w_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_base      <= CODE_BASE_RST;
            r_lead_threshold <= LEAD_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CODE_BASE:      r_code_base      <= i_cfg_data;
                CFG_LEAD_THRESHOLD: r_lead_threshold <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    fsca_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_byte        (i_in_byte),
        .i_lead_threshold (r_lead_threshold),
        .i_q_full         (w_q_full),
        .o_push           (w_push),
        .o_push_cmd       (w_push_cmd)
    );

    fsca_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_empty    (w_q_empty),
        .o_head     (w_q_head)
    );

    fsca_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_q_head       (w_q_head),
        .o_q_pop        (w_pop),
        .i_code_base    (r_code_base),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_was_inserted (o_was_inserted),
        .o_fill         (w_fill)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("command pushed into full queue");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= FILL_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (w_fill == $past(w_fill) || w_fill == $past(w_fill) + FILL_W'(1)))
        else $error("fill count moved by more than one");

endmodule

// File: hdl/fsca_ram.sv
module fsca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/fsca_queue.sv
module fsca_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fsca_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output fsca_pkg::t_cmd o_head
);
    import fsca_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: hdl/fsca_front.sv
module fsca_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fsca_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic [fsca_pkg::BYTE_W-1:0]   i_lead_threshold,
    input  logic                          i_q_full,
    output logic                          o_push,
    output fsca_pkg::t_cmd                o_push_cmd
);
    import fsca_pkg::*;

    logic [BYTE_W-1:0] r_held_lead;
    logic              r_lead_waiting;
    logic              w_accept;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    always_comb begin
        o_push           = 1'b0;
        o_push_cmd.op    = OP_PASS;
        o_push_cmd.lead  = i_in_byte;
        o_push_cmd.trail = ZERO_BYTE;
        if (w_accept) begin
            if (!r_lead_waiting) begin
                o_push = (i_in_byte < i_lead_threshold);
            end else begin
                o_push           = 1'b1;
                o_push_cmd.lead  = r_held_lead;
                o_push_cmd.trail = i_in_byte;
                o_push_cmd.op    = (i_in_byte == ZERO_BYTE) ? OP_FLUSH : OP_PAIR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lead    <= '0;
            r_lead_waiting <= 1'b0;
        end else if (w_accept) begin
            if (r_lead_waiting) begin
                r_lead_waiting <= 1'b0;
            end else if (i_in_byte >= i_lead_threshold) begin
                r_held_lead    <= i_in_byte;
                r_lead_waiting <= 1'b1;
            end
        end
    end

endmodule

// File: hdl/fsca_back.sv
module fsca_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  fsca_pkg::t_cmd                i_q_head,
    output logic                          o_q_pop,
    input  logic [fsca_pkg::CODE_W-1:0]   i_code_base,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fsca_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_run_last,
    output logic                          o_was_inserted,
    output logic [fsca_pkg::FILL_W-1:0]   o_fill
);
    import fsca_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT0,
        S_EMIT1
    } t_state;

    t_state             r_state;
    logic [KEY_W-1:0]   r_key;
    logic [BYTE_W-1:0]  r_b0;
    logic [BYTE_W-1:0]  r_b1;
    logic               r_ins;
    logic [FILL_W-1:0]  r_scan;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_pend_slot;
    logic [FILL_W-1:0]  r_fill;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;
    logic               r_out_ins;

    logic [KEY_W-1:0]   w_rd_data;
    logic               w_out_free;
    logic               w_emit;
    logic               w_hit;
    logic               w_done_scan;
    logic               w_room;
    logic               w_we;
    logic [CODE_W-1:0]  w_hit_code;
    logic [CODE_W-1:0]  w_new_code;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = ((r_state == S_EMIT0) || (r_state == S_EMIT1)) && w_out_free;
    assign w_hit       = r_pend && (w_rd_data == r_key);
    assign w_done_scan = (r_scan == r_fill);
    assign w_room      = (r_fill < FILL_W'(TABLE_DEPTH));
    assign w_we        = (r_state == S_SCAN) && !w_hit && w_done_scan && w_room;
    assign w_hit_code  = i_code_base + CODE_W'(r_pend_slot);
    assign w_new_code  = i_code_base + CODE_W'(r_fill);
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;

    fsca_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_scan[ADDR_W-1:0]),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_key <= {i_q_head.trail, i_q_head.lead};
                        r_ins <= 1'b0;
                        case (i_q_head.op)
                            OP_PASS: begin
                                r_b1    <= i_q_head.lead;
                                r_state <= S_EMIT1;
                            end
                            OP_FLUSH: begin
                                r_b0    <= i_q_head.lead;
                                r_b1    <= ZERO_BYTE;
                                r_state <= S_EMIT0;
                            end
                            OP_PAIR: begin
                                r_scan  <= '0;
                                r_pend  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_b0    <= w_hit_code[CODE_W-1:BYTE_W];
                        r_b1    <= w_hit_code[BYTE_W-1:0];
                        r_ins   <= 1'b0;
                        r_state <= S_EMIT0;
                    end else if (w_done_scan) begin
                        if (w_room) begin
                            r_fill <= r_fill + FILL_W'(1);
                            r_b0   <= w_new_code[CODE_W-1:BYTE_W];
                            r_b1   <= w_new_code[BYTE_W-1:0];
                            r_ins  <= 1'b1;
                        end else begin
                            r_b0  <= r_key[BYTE_W-1:0];
                            r_b1  <= r_key[KEY_W-1:BYTE_W];
                            r_ins <= 1'b0;
                        end
                        r_state <= S_EMIT0;
                    end else begin
                        r_pend      <= 1'b1;
                        r_pend_slot <= r_scan[ADDR_W-1:0];
                        r_scan      <= r_scan + FILL_W'(1);
                    end
                end
                S_EMIT0: begin
                    if (w_out_free) begin
                        r_out_byte  <= r_b0;
                        r_out_last  <= 1'b0;
                        r_out_ins   <= r_ins;
                        r_state     <= S_EMIT1;
                    end
                end
                S_EMIT1: begin
                    if (w_out_free) begin
                        r_out_byte  <= r_b1;
                        r_out_last  <= 1'b1;
                        r_out_ins   <= r_ins;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_run_last     = r_out_last;
    assign o_was_inserted = r_out_ins;
    assign o_fill         = r_fill;

endmodule

// File: dv/first_seen_code_assigner_top_tb.sv
`timescale 1ns / 1ps

module first_seen_code_assigner_top_tb;
    import fsca_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              was_inserted;
    } t_res;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_RUNS
    } t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_in_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_run_last;
    logic                  o_was_inserted;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_CODE_BASE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // code-assignment state
    t_res              pending_bytes[$];
    int                slot_of_key [0:65535];
    int                used_slots = 0;
    logic [BYTE_W-1:0] lead_hold = '0;
    logic              lead_pending = 1'b0;
    logic [CODE_W-1:0] base_now = CODE_BASE_RST;
    logic [BYTE_W-1:0] thr_now = LEAD_THR_RST;

    int n_errors = 0;
    int n_bytes_in = 0;
    int n_results = 0;
    int n_cfg = 0;
    int burst_left = 1;
    int rx_left = 0;
    t_rx_mode rx_mode = RX_FREE;

    first_seen_code_assigner_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_was_inserted (o_was_inserted),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void push_result(input logic [7:0] b, input logic last,
                                        input logic ins);
        t_res r;
        r.out_byte     = b;
        r.run_last     = last;
        r.was_inserted = ins;
        pending_bytes.push_back(r);
    endfunction

    function automatic void assign_code(input logic [BYTE_W-1:0] b);
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] code;
        int                slot;
        logic              ins;
        ins = 1'b0;
        if (!lead_pending) begin
            if (b < thr_now) begin
                push_result(b, 1'b1, 1'b0);
            end else begin
                lead_hold    = b;
                lead_pending = 1'b1;
            end
            return;
        end
        lead_pending = 1'b0;
        if (b == ZERO_BYTE) begin
            push_result(lead_hold, 1'b0, 1'b0);
            push_result(ZERO_BYTE, 1'b1, 1'b0);
            return;
        end
        key = {b, lead_hold};
        if (slot_of_key[key] >= 0) begin
            slot = slot_of_key[key];
        end else if (used_slots < TABLE_DEPTH) begin
            slot = used_slots;
            slot_of_key[key] = used_slots;
            used_slots++;
            ins = 1'b1;
        end else begin
            // table full: the pair goes out as it came
            push_result(lead_hold, 1'b0, 1'b0);
            push_result(b, 1'b1, 1'b0);
            return;
        end
        code = base_now + slot[CODE_W-1:0];
        push_result(code[15:8], 1'b0, ins);
        push_result(code[7:0], 1'b1, ins);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        assign_code(b);
        n_bytes_in++;
    endtask

    task automatic feed(input logic [BYTE_W-1:0] b);
        send_byte(b);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic feed_pair(input logic [BYTE_W-1:0] lead, input logic [BYTE_W-1:0] trail);
        feed(lead);
        feed(trail);
    endtask

    // lets the last transfer finish before a register write
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] base,
                              input logic [CFG_DATA_W-1:0] thr_word);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CODE_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        base_now    = base;
        i_cfg_idx  <= CFG_LEAD_THRESHOLD;
        i_cfg_data <= thr_word;
        @(posedge i_clk);
        thr_now   = thr_word[BYTE_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_cfg += 2;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 2));
                rx_left <= $urandom_range(20, 120);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_FREE:   i_out_stall <= 1'b0;
                RX_RANDOM: i_out_stall <= ($urandom_range(0, 2) == 0);
                default:   i_out_stall <= rx_left[3];
            endcase
        end
    end

    always @(posedge i_clk) begin : check_out
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_bytes.size() == 0) begin
                $error("out_byte: expected nothing, got %02h", o_out_byte);
                n_errors++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, o_out_byte);
                    n_errors++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, o_run_last);
                    n_errors++;
                end
                if (o_was_inserted !== want.was_inserted) begin
                    $error("was_inserted: expected %0b, got %0b",
                           want.was_inserted, o_was_inserted);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_plain_bytes();
        feed(8'h00);
        feed(8'h01);
        feed(8'h7F);
        feed(8'h80);
    endtask

    task automatic test_pair_codes();
        feed_pair(8'h81, 8'h40);
        feed_pair(8'hFF, 8'hFF);
        feed_pair(8'h81, 8'h40);
        feed_pair(8'h81, 8'h01);
        feed_pair(8'hFF, 8'h80);
    endtask

    task automatic test_zero_after_lead();
        feed_pair(8'h90, ZERO_BYTE);
        feed_pair(8'hFF, ZERO_BYTE);
    endtask

    task automatic test_config_extremes();
        set_config(16'hFFFF, 16'h0001);
        feed(8'h00);
        feed_pair(8'hFF, 8'hFF);
        feed_pair(8'h01, 8'h02);
        set_config(16'h0000, 16'h00FF);
        feed(8'hFE);
        feed_pair(8'hFF, 8'h81);
        // threshold zero: every byte leads, a zero included
        set_config(16'h1234, 16'h0000);
        feed_pair(8'h00, ZERO_BYTE);
        feed_pair(8'h00, 8'h05);
        // upper data bits are dropped by the threshold register
        set_config(16'h7FFF, 16'hAB80);
        feed(8'h7F);
        feed_pair(8'h80, 8'h40);
    endtask

    task automatic random_unit();
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] trail;
        int                r;
        r    = $urandom_range(0, 9);
        lead = BYTE_W'($urandom_range(thr_now, 255));
        case ($urandom_range(0, 3))
            0:       trail = 8'h01;
            1:       trail = 8'hFF;
            default: trail = BYTE_W'($urandom_range(1, 6));
        endcase
        if (r < 6) begin
            feed_pair(lead, trail);
        end else if (r == 6) begin
            feed_pair(lead, ZERO_BYTE);
        end else if (r == 7 && thr_now != 0) begin
            feed(BYTE_W'($urandom_range(0, thr_now - 1)));
        end else begin
            feed(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_stream();
        logic [CFG_DATA_W-1:0] base;
        logic [CFG_DATA_W-1:0] thr_word;
        int                    start;
        for (int ph = 0; ph < 3; ph++) begin
            case ($urandom_range(0, 2))
                0:       base = 16'h0000;
                1:       base = 16'hFFFF;
                default: base = CFG_DATA_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       thr_word = 16'h0000;
                1:       thr_word = 16'h0001;
                2:       thr_word = 16'h00FF;
                default: thr_word = CFG_DATA_W'($urandom);
            endcase
            set_config(base, thr_word);
            start = n_bytes_in;
            while (n_bytes_in - start < 35) random_unit();
        end
    endtask

    initial begin
        for (int i = 0; i < 65536; i++) slot_of_key[i] = -1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_bytes();
        test_pair_codes();
        test_zero_after_lead();
        test_config_extremes();
        test_random_stream();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        $display("sent %0d stream bytes and checked %0d output bytes", n_bytes_in, n_results);
        $display("filled %0d of %0d table slots over %0d register writes",
                 used_slots, TABLE_DEPTH, n_cfg);
        if (n_errors == 0 && pending_bytes.size() == 0) begin
            $display("first_seen_code_assigner_top_tb passed");
        end else begin
            $display("first_seen_code_assigner_top_tb failed");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("first_seen_code_assigner_top_tb failed");
        $finish;
    end

endmodule
